// ===== sv/iafmt_pkg.sv =====
// ----------------------------------------------------------------------------
// iafmt_pkg: shared definitions for the integer-to-ASCII field formatter
// Field widths, format selector codes, ASCII constants and the digit
// character lookup used by the formatter datapath.
// ----------------------------------------------------------------------------
package iafmt_pkg;

  // Field widths of the input and result beats.
  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 2;
  localparam int FW_W    = 6;
  localparam int ROOM_W  = 8;
  localparam int CHAR_W  = 8;

  // Widest field that is honored; wider requests saturate here.
  localparam int MAX_WIDTH = 32;

  // Digit buffer depth and the width of its index.
  localparam int DIG_N  = 12;
  localparam int DIG_IW = $clog2(DIG_N);

  // Format selector codes. Bit 1 set selects hexadecimal.
  localparam logic [FUNC_W-1:0] FUNC_SDEC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UDEC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd2;

  // Reciprocal of ten: floor(x * 0xCCCCCCCD / 2^35) == x / 10 for 32-bit x.
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // ASCII constants.
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Map one digit value (0..15) to its upper-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== sv/integer_to_ascii_field_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter: printf-style integer to ASCII formatter
// Converts one 32-bit value per input beat into a run of ASCII characters
// (signed decimal, unsigned decimal or upper-case hex) with sign, padding,
// justification and an overflow fill of '#' when the buffer room is short.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+--------------------------------------
//  in      | input     | in_valid/in_stall | value, func, flags, field_width, room
//  out     | output    | out_valid/out_stall | out_char, out_last (one char a beat)
//
// Steps per item: accept in S_IDLE, then S_DIVQ and S_DIVR for each decimal digit
// through the shared reciprocal multiplier or S_DIVQ alone for each hex digit,
// then S_PLAN, then one character per cycle while the output register is free.
// The output register lets the last character wait while the next item is taken.
// rst_n is synchronous and active low; it clears the sequencer and out_valid.
// A stalled output holds the sequencer in its current character.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter
  import iafmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic                in_plus_sign,
  input  logic                in_zero_pad,
  input  logic                in_left_justify,
  input  logic [FW_W-1:0]     in_field_width,
  input  logic [ROOM_W-1:0]   in_room,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_char,
  output logic                out_last
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVQ = 4'd1;
  localparam logic [3:0] S_DIVR = 4'd2;
  localparam logic [3:0] S_PLAN = 4'd3;
  localparam logic [3:0] S_PFX1 = 4'd4;
  localparam logic [3:0] S_LPAD = 4'd5;
  localparam logic [3:0] S_PFX2 = 4'd6;
  localparam logic [3:0] S_DIG  = 4'd7;
  localparam logic [3:0] S_RPAD = 4'd8;
  localparam logic [3:0] S_HASH = 4'd9;

  localparam int               Q_W   = 64 - DIV10_SHIFT;
  localparam logic [FW_W-1:0]  MAX_W = FW_W'(MAX_WIDTH);

  // Control registers.
  logic [3:0]          state_r,     state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [VALUE_W-1:0]  mag_r,       mag_nxt;
  logic [Q_W-1:0]      q_r,         q_nxt;
  logic [DIG_IW-1:0]   nd_r,        nd_nxt;
  logic [DIG_IW-1:0]   didx_r,      didx_nxt;
  logic [FW_W-1:0]     pad_r,       pad_nxt;
  logic [ROOM_W-1:0]   rem_r,       rem_nxt;
  logic [FW_W-1:0]     width_r,     width_nxt;
  logic [ROOM_W-1:0]   room_r,      room_nxt;
  logic [CHAR_W-1:0]   pfx_r,       pfx_nxt;
  logic                has_pfx_r,   has_pfx_nxt;
  logic                hex_r,       hex_nxt;
  logic                zpad_r,      zpad_nxt;
  logic                ljust_r,     ljust_nxt;
  logic [CHAR_W-1:0]   out_char_r,  out_char_nxt;
  logic                out_last_r,  out_last_nxt;

  // Digit buffer, least significant digit first.
  logic [3:0]          dig_r [DIG_N];
  logic                dig_we;
  logic [3:0]          dig_wdata;

  // Shared arithmetic and planning terms.
  logic [63:0]         prod;
  logic [VALUE_W-1:0]  rem_val;
  logic                neg;
  logic [4:0]          len;
  logic                ovf;
  logic [FW_W-1:0]     wred;
  logic [FW_W-1:0]     pad_calc;
  logic                slot_free;
  logic                emit_state;
  logic                emit_go;
  logic [CHAR_W-1:0]   emit_char;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Reciprocal multiply for the quotient, then the remainder by shift-and-subtract.
  assign prod    = 64'(mag_r) * 64'(DIV10_MUL);
  assign rem_val = mag_r - {q_r, 3'b000} - {2'b00, q_r, 1'b0};

  // Sign handling of the incoming value.
  assign neg = (in_func == FUNC_SDEC) && in_value[VALUE_W-1];

  // Field planning once the digit count is known.
  assign len      = {1'b0, nd_r} + {4'd0, has_pfx_r};
  assign ovf      = {3'd0, len} > room_r;
  assign wred     = (has_pfx_r && (width_r != '0)) ? width_r - 1'b1 : width_r;
  assign pad_calc = (wred > {2'd0, nd_r}) ? wred - {2'd0, nd_r} : '0;

  // The output register may take a character when empty or draining.
  assign slot_free  = !out_valid_r || !out_stall;
  assign emit_state = (state_r == S_PFX1) || (state_r == S_LPAD) ||
                      (state_r == S_PFX2) || (state_r == S_DIG)  ||
                      (state_r == S_RPAD) || (state_r == S_HASH);
  assign emit_go    = emit_state && slot_free;

  // Character for the current emit state.
  always_comb begin
    unique case (state_r)
      S_PFX1, S_PFX2: emit_char = pfx_r;
      S_LPAD:         emit_char = zpad_r ? CH_ZERO : CH_SPACE;
      S_DIG:          emit_char = digit_char(dig_r[didx_r]);
      S_HASH:         emit_char = CH_HASH;
      default:        emit_char = CH_SPACE;
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    q_nxt         = q_r;
    nd_nxt        = nd_r;
    didx_nxt      = didx_r;
    pad_nxt       = pad_r;
    rem_nxt       = rem_r;
    width_nxt     = width_r;
    room_nxt      = room_r;
    pfx_nxt       = pfx_r;
    has_pfx_nxt   = has_pfx_r;
    hex_nxt       = hex_r;
    zpad_nxt      = zpad_r;
    ljust_nxt     = ljust_r;
    dig_we        = 1'b0;
    dig_wdata     = rem_val[3:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    // Load one character into the output register.
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = (rem_r == 8'd1);
      rem_nxt       = rem_r - 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt     = neg ? (VALUE_W'(0) - in_value) : in_value;
          pfx_nxt     = neg ? CH_MINUS : CH_PLUS;
          has_pfx_nxt = neg || in_plus_sign;
          // Bit 1 of the selector picks hexadecimal, so code three is hex too.
          hex_nxt     = in_func[1];
          zpad_nxt    = in_zero_pad;
          ljust_nxt   = in_left_justify;
          width_nxt   = (in_field_width > MAX_W) ? MAX_W : in_field_width;
          room_nxt    = in_room;
          nd_nxt      = '0;
          state_nxt   = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (hex_r) begin
          dig_we    = 1'b1;
          dig_wdata = mag_r[3:0];
          mag_nxt   = mag_r >> 4;
          nd_nxt    = nd_r + 1'b1;
          if (mag_r[VALUE_W-1:4] == '0) begin
            state_nxt = S_PLAN;
          end
        end else begin
          q_nxt     = prod[63:DIV10_SHIFT];
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        dig_we  = 1'b1;
        mag_nxt = VALUE_W'(q_r);
        nd_nxt  = nd_r + 1'b1;
        if (q_r == '0) begin
          state_nxt = S_PLAN;
        end else begin
          state_nxt = S_DIVQ;
        end
      end
      S_PLAN: begin
        pad_nxt  = pad_calc;
        didx_nxt = nd_r - 1'b1;
        if (ovf) begin
          rem_nxt   = room_r;
          state_nxt = (room_r == '0) ? S_IDLE : S_HASH;
        end else begin
          rem_nxt = {3'd0, len} + {2'd0, pad_calc};
          if (has_pfx_r && zpad_r) begin
            state_nxt = S_PFX1;
          end else if (!ljust_r && (pad_calc != '0)) begin
            state_nxt = S_LPAD;
          end else if (has_pfx_r) begin
            state_nxt = S_PFX2;
          end else begin
            state_nxt = S_DIG;
          end
        end
      end
      S_PFX1: begin
        if (emit_go) begin
          state_nxt = (!ljust_r && (pad_r != '0)) ? S_LPAD : S_DIG;
        end
      end
      S_LPAD: begin
        if (emit_go) begin
          pad_nxt = pad_r - 1'b1;
          if (pad_r == FW_W'(1)) begin
            state_nxt = (has_pfx_r && !zpad_r) ? S_PFX2 : S_DIG;
          end
        end
      end
      S_PFX2: begin
        if (emit_go) begin
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (emit_go) begin
          didx_nxt = didx_r - 1'b1;
          if (rem_r == 8'd1) begin
            state_nxt = S_IDLE;
          end else if (didx_r == '0) begin
            state_nxt = S_RPAD;
          end
        end
      end
      S_RPAD, S_HASH: begin
        if (emit_go && (rem_r == 8'd1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    q_r        <= q_nxt;
    nd_r       <= nd_nxt;
    didx_r     <= didx_nxt;
    pad_r      <= pad_nxt;
    rem_r      <= rem_nxt;
    width_r    <= width_nxt;
    room_r     <= room_nxt;
    pfx_r      <= pfx_nxt;
    has_pfx_r  <= has_pfx_nxt;
    hex_r      <= hex_nxt;
    zpad_r     <= zpad_nxt;
    ljust_r    <= ljust_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer write.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[nd_r] <= dig_wdata;
    end
  end

endmodule

// ===== sv/iafmt_chk.sv =====
// ----------------------------------------------------------------------------
// iafmt_chk: port-level checker for the integer-to-ASCII field formatter
// Watches the handshakes of the formatter and flags sequencing errors.
// ----------------------------------------------------------------------------
module iafmt_chk
  import iafmt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  // An accepted beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("formatter ready right after accepting a beat");

  // While ready for a new item, any pending character must close the last item.
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !in_stall) |-> out_last)
    else $error("formatter idle while an item is still being emitted");

  // A stalled result beat stays valid.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_char) && $stable(out_last)))
    else $error("result payload changed while stalled");

endmodule

bind integer_to_ascii_field_formatter iafmt_chk u_iafmt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_last  (out_last)
);

// ===== dv/iafmt_char_checker.sv =====
// ----------------------------------------------------------------------------
// iafmt_char_checker: character stream checker for the field formatter
// Watches both channels of the formatter. Every accepted input beat is turned
// into the characters it should produce. Every accepted result beat is then
// compared with the oldest character still owed. The number of characters
// still owed and the failure count are handed back to the testbench top.
// ----------------------------------------------------------------------------
module iafmt_char_checker
  import iafmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic               in_plus_sign,
  input  logic               in_zero_pad,
  input  logic               in_left_justify,
  input  logic [FW_W-1:0]    in_field_width,
  input  logic [ROOM_W-1:0]  in_room,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CHAR_W-1:0]  out_char,
  input  logic               out_last,
  output int                 n_pending,
  output int                 n_errors
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  // Characters owed by the block, oldest first.
  char_beat_t expected_chars[$];

  // Work out the characters of one formatted field and queue them.
  function automatic void predict_chars(
    input logic [VALUE_W-1:0] value,
    input logic [FUNC_W-1:0]  func,
    input logic               plus_sign,
    input logic               zero_pad,
    input logic               left_justify,
    input logic [FW_W-1:0]    field_width,
    input logic [ROOM_W-1:0]  room
  );
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs [DIG_N];
    logic [CHAR_W-1:0]  prefix;
    logic [CHAR_W-1:0]  pad_ch;
    logic [CHAR_W-1:0]  text [$];
    logic               is_hex;
    int                 nd;
    int                 wid;
    int                 npad;
    int                 len;
    char_beat_t         beat;

    is_hex = func[1];
    wid    = (int'(field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(field_width);
    pad_ch = zero_pad ? CH_ZERO : CH_SPACE;
    mag    = value;
    prefix = '0;
    if (plus_sign) begin
      prefix = CH_PLUS;
    end
    if (func == FUNC_SDEC && value[VALUE_W-1]) begin
      prefix = CH_MINUS;
      mag    = -value;
    end

    // Digits come out least significant first.
    nd = 0;
    do begin
      if (is_hex) begin
        digs[nd] = mag[3:0];
        mag      = mag >> 4;
      end else begin
        digs[nd] = 4'(mag % 10);
        mag      = mag / 10;
      end
      nd++;
    end while (mag != 0 && nd < DIG_N);

    len = nd + ((prefix != 0) ? 1 : 0);
    if (len > int'(room)) begin
      // Not enough room: fill what is left with hash marks.
      for (int i = 0; i < int'(room); i++) begin
        text.push_back(CH_HASH);
      end
    end else begin
      // The prefix takes one column of the field.
      if (prefix != 0 && wid > 0) begin
        wid--;
      end
      npad = (wid > nd) ? wid - nd : 0;
      if (prefix != 0 && zero_pad) begin
        text.push_back(prefix);
      end
      if (!left_justify) begin
        for (int i = 0; i < npad; i++) begin
          text.push_back(pad_ch);
        end
      end
      if (prefix != 0 && !zero_pad) begin
        text.push_back(prefix);
      end
      for (int i = nd - 1; i >= 0; i--) begin
        if (digs[i] < 4'd10) begin
          text.push_back(CH_ZERO + CHAR_W'(digs[i]));
        end else begin
          text.push_back(CH_UPA + CHAR_W'(digs[i]) - CHAR_W'(10));
        end
      end
      if (left_justify) begin
        for (int i = 0; i < npad; i++) begin
          text.push_back(CH_SPACE);
        end
      end
    end

    foreach (text[i]) begin
      beat.ch   = text[i];
      beat.last = (i == text.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  // Compare each result beat, then record what a new input beat owes.
  always @(posedge clk) begin : watch
    int         bad;
    char_beat_t want;
    bad = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result beat: char 0x%02h last %0b",
                   $time, out_char, out_last);
          bad++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: char mismatch: expected 0x%02h actual 0x%02h",
                     $time, want.ch, out_char);
            bad++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %0b actual %0b",
                     $time, want.last, out_last);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_chars(in_value, in_func, in_plus_sign, in_zero_pad,
                      in_left_justify, in_field_width, in_room);
      end
    end
    n_pending <= expected_chars.size();
    n_errors  <= n_errors + bad;
  end

endmodule

// ===== dv/integer_to_ascii_field_formatter_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter_test: testbench for the field formatter
// Drives a directed set of corner cases and then random formatting requests
// through the block under several mixes of sender gaps and receiver stalls.
// The checker beside the block predicts and compares every character; this
// top only makes stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter_test;
  import iafmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 27;

  // Selector three decodes as hex since only bit 1 picks the base.
  localparam logic [FUNC_W-1:0] FUNC_HEX_ALT = FUNC_HEX | FUNC_UDEC;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value        = '0;
  logic [FUNC_W-1:0]  in_func         = FUNC_SDEC;
  logic               in_plus_sign    = 1'b0;
  logic               in_zero_pad     = 1'b0;
  logic               in_left_justify = 1'b0;
  logic [FW_W-1:0]    in_field_width  = '0;
  logic [ROOM_W-1:0]  in_room         = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int n_pending;
  int n_errors;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  integer_to_ascii_field_formatter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_func         (in_func),
    .in_plus_sign    (in_plus_sign),
    .in_zero_pad     (in_zero_pad),
    .in_left_justify (in_left_justify),
    .in_field_width  (in_field_width),
    .in_room         (in_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last        (out_last)
  );

  iafmt_char_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_func         (in_func),
    .in_plus_sign    (in_plus_sign),
    .in_zero_pad     (in_zero_pad),
    .in_left_justify (in_left_justify),
    .in_field_width  (in_field_width),
    .in_room         (in_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last        (out_last),
    .n_pending       (n_pending),
    .n_errors        (n_errors)
  );

  // Receiver backpressure at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** integer_to_ascii_field_formatter: FAILED **");
      $finish;
    end
  end

  // Offer one request beat, with an optional gap first, and wait for it to go.
  task automatic send_fmt(
    input logic [VALUE_W-1:0] value,
    input logic [FUNC_W-1:0]  func,
    input logic               plus_sign,
    input logic               zero_pad,
    input logic               left_justify,
    input logic [FW_W-1:0]    field_width,
    input logic [ROOM_W-1:0]  room
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_value        <= value;
    in_func         <= func;
    in_plus_sign    <= plus_sign;
    in_zero_pad     <= zero_pad;
    in_left_justify <= left_justify;
    in_field_width  <= field_width;
    in_room         <= room;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending until every owed character has come out.
  task automatic drain_chars();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // One random request, biased toward short widths and tight room.
  task automatic send_random();
    logic [VALUE_W-1:0] v;
    logic [FW_W-1:0]    w;
    logic [ROOM_W-1:0]  r;
    int                 pick;
    pick = $urandom_range(0, 9);
    case (pick)
      4, 5:    v = $urandom_range(0, 999);
      6:       v = -$urandom_range(1, 999);
      7: begin
        case ($urandom_range(0, 2))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      8:       v = $urandom_range(0, 15);
      9:       v = $urandom & 32'h0000_FFFF;
      default: v = $urandom;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      w = FW_W'($urandom_range(0, 16));
    end else if (pick < 9) begin
      w = FW_W'($urandom_range(17, 32));
    end else begin
      w = FW_W'($urandom_range(33, 63));
    end
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      r = 8'd255;
    end else if (pick < 8) begin
      r = ROOM_W'($urandom_range(0, 12));
    end else begin
      r = ROOM_W'($urandom_range(13, 254));
    end
    send_fmt(v, FUNC_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w, r);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases: extremes, every mode, prefixes, padding, room.
    send_fmt(32'd0,          FUNC_SDEC,    1'b0, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'h8000_0000,  FUNC_SDEC,    1'b0, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'hFFFF_FFFF,  FUNC_SDEC,    1'b1, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'hFFFF_FFFF,  FUNC_UDEC,    1'b0, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'hFFFF_FFFF,  FUNC_HEX,     1'b0, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'h7FFF_FFFF,  FUNC_SDEC,    1'b1, 1'b0, 1'b0, 6'd0,  8'd255);
    send_fmt(32'd123,        FUNC_UDEC,    1'b1, 1'b1, 1'b0, 6'd8,  8'd255);
    send_fmt(32'd123,        FUNC_SDEC,    1'b1, 1'b0, 1'b0, 6'd8,  8'd255);
    send_fmt(32'hFFFF_FFD6,  FUNC_SDEC,    1'b0, 1'b0, 1'b1, 6'd10, 8'd255);
    send_fmt(32'h0000_0ABC,  FUNC_HEX_ALT, 1'b0, 1'b1, 1'b0, 6'd6,  8'd255);
    send_fmt(32'd5,          FUNC_UDEC,    1'b0, 1'b0, 1'b0, 6'd63, 8'd255);
    send_fmt(32'd5,          FUNC_HEX,     1'b0, 1'b1, 1'b1, 6'd63, 8'd255);
    send_fmt(32'hFFFF_FF85,  FUNC_SDEC,    1'b1, 1'b1, 1'b1, 6'd9,  8'd255);
    send_fmt(32'd1234,       FUNC_UDEC,    1'b0, 1'b0, 1'b0, 6'd0,  8'd0);
    send_fmt(32'd123456,     FUNC_UDEC,    1'b0, 1'b0, 1'b0, 6'd20, 8'd3);
    send_fmt(32'd123,        FUNC_UDEC,    1'b1, 1'b0, 1'b0, 6'd10, 8'd4);
    send_fmt(32'd123,        FUNC_UDEC,    1'b1, 1'b0, 1'b0, 6'd0,  8'd3);
    send_fmt(32'd77,         FUNC_HEX,     1'b0, 1'b0, 1'b0, 6'd0,  8'd1);
    send_fmt(32'd9,          FUNC_SDEC,    1'b1, 1'b1, 1'b0, 6'd1,  8'd255);
    send_fmt(32'd0,          FUNC_UDEC,    1'b0, 1'b1, 1'b0, 6'd32, 8'd255);
    send_fmt(32'hDEAD_BEEF,  FUNC_HEX,     1'b1, 1'b0, 1'b0, 6'd20, 8'd255);
    send_fmt(32'd0,          FUNC_HEX_ALT, 1'b0, 1'b0, 1'b1, 6'd32, 8'd255);
    send_fmt(32'h8000_0000,  FUNC_SDEC,    1'b1, 1'b0, 1'b0, 6'd0,  8'd11);
    drain_chars();

    // Random requests under each mix of sender gaps and receiver stalls.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (PHASE_ITEMS) send_random();
      drain_chars();
    end

    // Let any request that owes no characters finish inside the block.
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("** integer_to_ascii_field_formatter: PASSED **");
    end else begin
      $display("** integer_to_ascii_field_formatter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/iafmt_pkg.sv
sv/integer_to_ascii_field_formatter.sv
sv/iafmt_chk.sv
dv/iafmt_char_checker.sv
dv/integer_to_ascii_field_formatter_test.sv
